### rtl/qacc_pkg.sv
package qacc_pkg;

   localparam int DATA_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF  = 14;
   localparam int STEP_W         = 5;

   localparam logic [2:0] OP_LOAD = 3'd0;
   localparam logic [2:0] OP_MUL  = 3'd1;
   localparam logic [2:0] OP_ADD  = 3'd2;
   localparam logic [2:0] OP_CONJ = 3'd3;
   localparam logic [2:0] OP_NORM = 3'd4;
   localparam logic [2:0] OP_MAT  = 3'd5;

   // Left operand: accumulator component.
   localparam logic [1:0] AX = 2'd0;
   localparam logic [1:0] AY = 2'd1;
   localparam logic [1:0] AZ = 2'd2;
   localparam logic [1:0] AW = 2'd3;
   // Right operand: accumulator component or request operand.
   localparam logic [2:0] BX = 3'd0;
   localparam logic [2:0] BY = 3'd1;
   localparam logic [2:0] BZ = 3'd2;
   localparam logic [2:0] BW = 3'd3;
   localparam logic [2:0] OX = 3'd4;
   localparam logic [2:0] OY = 3'd5;
   localparam logic [2:0] OZ = 3'd6;
   localparam logic [2:0] OW = 3'd7;

   typedef struct packed {
      logic [1:0] a_sel;
      logic [2:0] b_sel;
      logic       neg;
      logic       dbl;
      logic [1:0] col;
      logic       raw;
      logic       last;
   } micro_type;

   typedef struct packed {
      logic sqrt_go;
      logic div_go;
   } rd_cmd_type;

   function automatic micro_type mk(logic [1:0] a, logic [2:0] b, logic n, logic d,
                                    logic [1:0] c, logic l);
      micro_type m;
      m.a_sel = a;
      m.b_sel = b;
      m.neg   = n;
      m.dbl   = d;
      m.col   = c;
      m.raw   = 1'b0;
      m.last  = l;
      return m;
   endfunction

   function automatic micro_type mk_sq(logic [1:0] a, logic l);
      micro_type m;
      m       = mk(a, {1'b0, a}, 1'b0, 1'b0, 2'd0, l);
      m.raw   = 1'b1;
      return m;
   endfunction

   // Product schedule of the shared multiplier for each operation.
   function automatic micro_type micro_code(logic [2:0] op, logic [STEP_W-1:0] step);
      micro_type m;
      m = mk(AX, BX, 1'b0, 1'b0, 2'd0, 1'b1);
      case (op)
         OP_MUL: begin
            case (step)
               5'd0:  m = mk(AW, OX, 1'b0, 1'b0, 2'd0, 1'b0);
               5'd1:  m = mk(AX, OW, 1'b0, 1'b0, 2'd0, 1'b0);
               5'd2:  m = mk(AY, OZ, 1'b0, 1'b0, 2'd0, 1'b0);
               5'd3:  m = mk(AZ, OY, 1'b1, 1'b0, 2'd0, 1'b0);
               5'd4:  m = mk(AW, OY, 1'b0, 1'b0, 2'd1, 1'b0);
               5'd5:  m = mk(AY, OW, 1'b0, 1'b0, 2'd1, 1'b0);
               5'd6:  m = mk(AZ, OX, 1'b0, 1'b0, 2'd1, 1'b0);
               5'd7:  m = mk(AX, OZ, 1'b1, 1'b0, 2'd1, 1'b0);
               5'd8:  m = mk(AW, OZ, 1'b0, 1'b0, 2'd2, 1'b0);
               5'd9:  m = mk(AZ, OW, 1'b0, 1'b0, 2'd2, 1'b0);
               5'd10: m = mk(AX, OY, 1'b0, 1'b0, 2'd2, 1'b0);
               5'd11: m = mk(AY, OX, 1'b1, 1'b0, 2'd2, 1'b0);
               5'd12: m = mk(AW, OW, 1'b0, 1'b0, 2'd3, 1'b0);
               5'd13: m = mk(AX, OX, 1'b1, 1'b0, 2'd3, 1'b0);
               5'd14: m = mk(AY, OY, 1'b1, 1'b0, 2'd3, 1'b0);
               default: m = mk(AZ, OZ, 1'b1, 1'b0, 2'd3, 1'b1);
            endcase
         end
         OP_MAT: begin
            case (step)
               5'd0:  m = mk(AW, BW, 1'b0, 1'b0, 2'd0, 1'b0);
               5'd1:  m = mk(AX, BX, 1'b0, 1'b0, 2'd0, 1'b0);
               5'd2:  m = mk(AY, BY, 1'b1, 1'b0, 2'd0, 1'b0);
               5'd3:  m = mk(AZ, BZ, 1'b1, 1'b0, 2'd0, 1'b0);
               5'd4:  m = mk(AX, BY, 1'b0, 1'b1, 2'd1, 1'b0);
               5'd5:  m = mk(AW, BZ, 1'b1, 1'b1, 2'd1, 1'b0);
               5'd6:  m = mk(AX, BZ, 1'b0, 1'b1, 2'd2, 1'b0);
               5'd7:  m = mk(AW, BY, 1'b0, 1'b1, 2'd2, 1'b1);
               5'd8:  m = mk(AX, BY, 1'b0, 1'b1, 2'd0, 1'b0);
               5'd9:  m = mk(AW, BZ, 1'b0, 1'b1, 2'd0, 1'b0);
               5'd10: m = mk(AW, BW, 1'b0, 1'b0, 2'd1, 1'b0);
               5'd11: m = mk(AX, BX, 1'b1, 1'b0, 2'd1, 1'b0);
               5'd12: m = mk(AY, BY, 1'b0, 1'b0, 2'd1, 1'b0);
               5'd13: m = mk(AZ, BZ, 1'b1, 1'b0, 2'd1, 1'b0);
               5'd14: m = mk(AY, BZ, 1'b0, 1'b1, 2'd2, 1'b0);
               5'd15: m = mk(AW, BX, 1'b1, 1'b1, 2'd2, 1'b1);
               5'd16: m = mk(AX, BZ, 1'b0, 1'b1, 2'd0, 1'b0);
               5'd17: m = mk(AW, BY, 1'b1, 1'b1, 2'd0, 1'b0);
               5'd18: m = mk(AY, BZ, 1'b0, 1'b1, 2'd1, 1'b0);
               5'd19: m = mk(AW, BX, 1'b0, 1'b1, 2'd1, 1'b0);
               5'd20: m = mk(AW, BW, 1'b0, 1'b0, 2'd2, 1'b0);
               5'd21: m = mk(AX, BX, 1'b1, 1'b0, 2'd2, 1'b0);
               5'd22: m = mk(AY, BY, 1'b1, 1'b0, 2'd2, 1'b0);
               5'd23: m = mk(AZ, BZ, 1'b0, 1'b0, 2'd2, 1'b1);
               5'd24: m = mk(AW, BW, 1'b0, 1'b0, 2'd3, 1'b0);
               5'd25: m = mk(AX, BX, 1'b0, 1'b0, 2'd3, 1'b0);
               5'd26: m = mk(AY, BY, 1'b0, 1'b0, 2'd3, 1'b0);
               default: m = mk(AZ, BZ, 1'b0, 1'b0, 2'd3, 1'b1);
            endcase
         end
         OP_NORM: begin
            case (step)
               5'd0:  m = mk_sq(AX, 1'b0);
               5'd1:  m = mk_sq(AY, 1'b0);
               5'd2:  m = mk_sq(AZ, 1'b0);
               default: m = mk_sq(AW, 1'b1);
            endcase
         end
         default: m = mk(AX, BX, 1'b0, 1'b0, 2'd0, 1'b1);
      endcase
      return m;
   endfunction

endpackage

### rtl/quaternion_accumulator_unit.sv
// Channel   Dir  Handshake            Payload
// req       in   req_tvalid/tready    tdata: in_x, in_y, in_z, in_w; tuser: operation
// rsp       out  rsp_tvalid/tready    tdata: row_index, col0..col3; tlast; tuser: divide_error
//
// Load, add and conjugate pass through the apply and emit states before the registered result.
// Multiply issues 16 products through the one shared multiplier stage.
// Read matrix issues 28 products on the same multiplier and emits a row after each group of them.
// Normalize sums the four squares, then runs the bit-serial square root and one divide per
// component. Synchronous reset loads the identity quaternion.
// The request side is ready only when idle; a result waiting on the output does not stall it.
module quaternion_accumulator_unit import qacc_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // in_x, in_y, in_z, in_w from the lowest bit up, zero fill on top
   input  logic [((4*DATA_WIDTH+7)/8)*8-1:0]       req_tdata,
   // operation
   input  logic [2:0]                              req_tuser,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // row_index, col0, col1, col2, col3 from the lowest bit up, zero fill on top
   output logic [((4*DATA_WIDTH+9)/8)*8-1:0]       rsp_tdata,
   output logic                                    rsp_tlast,
   // divide_error
   output logic                                    rsp_tuser
);

   localparam int DW  = DATA_WIDTH;
   localparam int PW  = 2 * DW;
   localparam int CW  = 2 * DW + 2;
   localparam int SW  = 2 * DW + 1;
   localparam int OTW = ((4 * DW + 9) / 8) * 8;
   localparam logic signed [CW-1:0] CMAX = {{(CW-DW+1){1'b0}}, {(DW-1){1'b1}}};
   localparam logic signed [CW-1:0] CMIN = ~CMAX;
   localparam logic signed [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] DMIN = ~DMAX;
   localparam logic signed [DW-1:0] ONE  = (FRAC_BITS >= DW - 1) ? DMAX : DW'(1) << FRAC_BITS;
   localparam logic signed [CW-1:0] HALF = CW'(1) << (FRAC_BITS - 1);

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_APPLY = 9'b000000010,
      ST_MAC   = 9'b000000100,
      ST_DRAIN = 9'b000001000,
      ST_GROUP = 9'b000010000,
      ST_ROOT  = 9'b000100000,
      ST_DIVGO = 9'b001000000,
      ST_DIV   = 9'b010000000,
      ST_EMIT  = 9'b100000000
   } state_type;

   function automatic logic signed [DW-1:0] sat_c(logic signed [CW-1:0] v);
      if (v > CMAX) return DMAX;
      if (v < CMIN) return DMIN;
      return v[DW-1:0];
   endfunction

   function automatic logic signed [DW-1:0] sat_add(logic signed [DW-1:0] a,
                                                    logic signed [DW-1:0] b);
      logic signed [DW:0] s;
      s = {a[DW-1], a} + {b[DW-1], b};
      if (s[DW] != s[DW-1]) return s[DW] ? DMIN : DMAX;
      return s[DW-1:0];
   endfunction

   function automatic logic signed [DW-1:0] pick(logic [1:0] sel,
      logic signed [DW-1:0] x, logic signed [DW-1:0] y,
      logic signed [DW-1:0] z, logic signed [DW-1:0] w);
      case (sel)
         2'd0:    return x;
         2'd1:    return y;
         2'd2:    return z;
         default: return w;
      endcase
   endfunction

   state_type             state_ff, state_in;
   logic [2:0]            op_ff, op_in;
   logic signed [DW-1:0]  in_x_ff, in_y_ff, in_z_ff, in_w_ff;
   logic signed [DW-1:0]  in_x_in, in_y_in, in_z_in, in_w_in;
   logic signed [DW-1:0]  acc_x_ff, acc_y_ff, acc_z_ff, acc_w_ff;
   logic signed [DW-1:0]  acc_x_in, acc_y_in, acc_z_in, acc_w_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [1:0]            row_ff, row_in;
   logic [1:0]            comp_ff, comp_in;
   logic                  err_ff, err_in;
   logic signed [CW-1:0]  col_ff [4];
   logic [SW-1:0]         sum_ff;
   logic                  clear_cols;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OTW-1:0]        rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_err_ff, rsp_err_in;

   micro_type             mc;
   logic                  issue;
   logic signed [DW-1:0]  op_a, op_b;
   logic                  prod_valid;
   micro_type             prod_tag;
   logic signed [PW-1:0]  prod;
   logic signed [CW-1:0]  rounded, term;

   rd_cmd_type            rd_cmd;
   logic [SW-1:0]         radicand;
   logic signed [DW-1:0]  dividend, quotient;
   logic                  rd_done;
   logic                  out_free;

   assign mc    = micro_code(op_ff, step_ff);
   assign issue = (state_ff == ST_MAC);
   assign op_a  = pick(mc.a_sel, acc_x_ff, acc_y_ff, acc_z_ff, acc_w_ff);
   assign op_b  = mc.b_sel[2] ? pick(mc.b_sel[1:0], in_x_ff, in_y_ff, in_z_ff, in_w_ff)
                              : pick(mc.b_sel[1:0], acc_x_ff, acc_y_ff, acc_z_ff, acc_w_ff);

   qacc_mac #(.DATA_WIDTH(DATA_WIDTH)) u_mac (
      .clock      (clock),
      .reset      (reset),
      .issue      (issue),
      .tag        (mc),
      .op_a       (op_a),
      .op_b       (op_b),
      .prod_valid (prod_valid),
      .prod_tag   (prod_tag),
      .prod       (prod)
   );

   // Round half up to FRAC_BITS fraction bits, then apply the doubling and sign.
   assign rounded = ($signed({{2{prod[PW-1]}}, prod}) + HALF) >>> FRAC_BITS;
   always_comb begin
      term = prod_tag.dbl ? (rounded <<< 1) : rounded;
      if (prod_tag.neg) begin
         term = -term;
      end
   end

   // When SW exceeds 64, a squared sum of 2^(SW-1) and above is clamped to 2^(SW-1)-1.
   generate
      if (SW > 64) begin : g_clamp
         assign radicand = sum_ff[SW-1] ? {1'b0, {(SW-1){1'b1}}} : sum_ff;
      end else begin : g_noclamp
         assign radicand = sum_ff;
      end
   endgenerate

   assign dividend = pick(comp_ff, acc_x_ff, acc_y_ff, acc_z_ff, acc_w_ff);

   qacc_rootdiv #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_rootdiv (
      .clock    (clock),
      .reset    (reset),
      .cmd      (rd_cmd),
      .radicand (radicand),
      .dividend (dividend),
      .done     (rd_done),
      .quotient (quotient)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      in_x_in      = in_x_ff;
      in_y_in      = in_y_ff;
      in_z_in      = in_z_ff;
      in_w_in      = in_w_ff;
      acc_x_in     = acc_x_ff;
      acc_y_in     = acc_y_ff;
      acc_z_in     = acc_z_ff;
      acc_w_in     = acc_w_ff;
      step_in      = step_ff;
      row_in       = row_ff;
      comp_in      = comp_ff;
      err_in       = err_ff;
      clear_cols   = 1'b0;
      rd_cmd       = '0;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_err_in   = rsp_err_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in      = req_tuser;
               in_x_in    = req_tdata[DW-1:0];
               in_y_in    = req_tdata[2*DW-1:DW];
               in_z_in    = req_tdata[3*DW-1:2*DW];
               in_w_in    = req_tdata[4*DW-1:3*DW];
               step_in    = '0;
               row_in     = '0;
               err_in     = 1'b0;
               clear_cols = 1'b1;
               if (req_tuser inside {OP_MUL, OP_MAT, OP_NORM}) begin
                  state_in = ST_MAC;
               end else begin
                  state_in = ST_APPLY;
               end
            end
         end
         ST_APPLY: begin
            case (op_ff)
               OP_LOAD: begin
                  acc_x_in = in_x_ff;
                  acc_y_in = in_y_ff;
                  acc_z_in = in_z_ff;
                  acc_w_in = in_w_ff;
               end
               OP_ADD: begin
                  acc_x_in = sat_add(acc_x_ff, in_x_ff);
                  acc_y_in = sat_add(acc_y_ff, in_y_ff);
                  acc_z_in = sat_add(acc_z_ff, in_z_ff);
                  acc_w_in = sat_add(acc_w_ff, in_w_ff);
               end
               OP_CONJ: begin
                  acc_x_in = (acc_x_ff == DMIN) ? DMAX : -acc_x_ff;
                  acc_y_in = (acc_y_ff == DMIN) ? DMAX : -acc_y_ff;
                  acc_z_in = (acc_z_ff == DMIN) ? DMAX : -acc_z_ff;
               end
               default: ;
            endcase
            state_in = ST_EMIT;
         end
         ST_MAC: begin
            step_in = step_ff + STEP_W'(1);
            if (mc.last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_GROUP;
         end
         ST_GROUP: begin
            if (op_ff == OP_MUL) begin
               acc_x_in = sat_c(col_ff[0]);
               acc_y_in = sat_c(col_ff[1]);
               acc_z_in = sat_c(col_ff[2]);
               acc_w_in = sat_c(col_ff[3]);
               state_in = ST_EMIT;
            end else if (op_ff == OP_NORM) begin
               if (sum_ff == '0) begin
                  err_in   = 1'b1;
                  state_in = ST_EMIT;
               end else begin
                  rd_cmd.sqrt_go = 1'b1;
                  state_in       = ST_ROOT;
               end
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_ROOT: begin
            if (rd_done) begin
               comp_in  = '0;
               state_in = ST_DIVGO;
            end
         end
         ST_DIVGO: begin
            rd_cmd.div_go = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (rd_done) begin
               case (comp_ff)
                  2'd0:    acc_x_in = quotient;
                  2'd1:    acc_y_in = quotient;
                  2'd2:    acc_z_in = quotient;
                  default: acc_w_in = quotient;
               endcase
               comp_in  = comp_ff + 2'd1;
               state_in = (comp_ff == 2'd3) ? ST_EMIT : ST_DIVGO;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (op_ff == OP_MAT) begin
                  rsp_data_in = OTW'({sat_c(col_ff[3]), sat_c(col_ff[2]),
                                      sat_c(col_ff[1]), sat_c(col_ff[0]), row_ff});
                  rsp_last_in = (row_ff == 2'd3);
                  rsp_err_in  = 1'b0;
                  if (row_ff == 2'd3) begin
                     state_in = ST_IDLE;
                  end else begin
                     row_in     = row_ff + 2'd1;
                     clear_cols = 1'b1;
                     state_in   = ST_MAC;
                  end
               end else begin
                  rsp_data_in = OTW'({acc_w_ff, acc_z_ff, acc_y_ff, acc_x_ff, 2'd0});
                  rsp_last_in = 1'b1;
                  rsp_err_in  = err_ff;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_x_ff     <= '0;
         acc_y_ff     <= '0;
         acc_z_ff     <= '0;
         acc_w_ff     <= ONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_x_ff     <= acc_x_in;
         acc_y_ff     <= acc_y_in;
         acc_z_ff     <= acc_z_in;
         acc_w_ff     <= acc_w_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      in_x_ff     <= in_x_in;
      in_y_ff     <= in_y_in;
      in_z_ff     <= in_z_in;
      in_w_ff     <= in_w_in;
      step_ff     <= step_in;
      row_ff      <= row_in;
      comp_ff     <= comp_in;
      err_ff      <= err_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_err_ff  <= rsp_err_in;
   end

   // Products land in the cycle after issue and are summed into their column, or into the square sum when raw.
   always_ff @(posedge clock) begin
      if (clear_cols) begin
         for (int i = 0; i < 4; i++) begin
            col_ff[i] <= '0;
         end
         sum_ff <= '0;
      end else if (prod_valid) begin
         if (prod_tag.raw) begin
            sum_ff <= sum_ff + SW'(unsigned'(prod));
         end else begin
            col_ff[prod_tag.col] <= col_ff[prod_tag.col] + term;
         end
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_err_ff;

endmodule

### rtl/qacc_mac.sv
module qacc_mac import qacc_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          issue,
   input  micro_type                     tag,
   input  logic signed [DATA_WIDTH-1:0]  op_a,
   input  logic signed [DATA_WIDTH-1:0]  op_b,
   output logic                          prod_valid,
   output micro_type                     prod_tag,
   output logic signed [2*DATA_WIDTH-1:0] prod
);

   logic                          valid_ff, valid_in;
   micro_type                     tag_ff;
   logic signed [2*DATA_WIDTH-1:0] prod_ff, prod_in;

   assign valid_in = issue;
   assign prod_in  = op_a * op_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff  <= tag;
      prod_ff <= prod_in;
   end

   assign prod_valid = valid_ff;
   assign prod_tag   = tag_ff;
   assign prod       = prod_ff;

endmodule

### rtl/qacc_rootdiv.sv
module qacc_rootdiv import qacc_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rd_cmd_type                    cmd,
   input  logic [2*DATA_WIDTH:0]         radicand,
   input  logic signed [DATA_WIDTH-1:0]  dividend,
   output logic                          done,
   output logic signed [DATA_WIDTH-1:0]  quotient
);

   localparam int DW   = DATA_WIDTH;
   localparam int NW   = 2 * DW + 2;
   localparam int RW   = DW + 1;
   localparam int RMW  = DW + 3;
   localparam int DRW  = DW + 2;
   localparam int QW   = FRAC_BITS + 2;
   localparam int XW   = (QW > DW + 1) ? QW : DW + 1;
   localparam int CMV  = (DW + 1 > FRAC_BITS + 1) ? DW + 1 : FRAC_BITS + 1;
   localparam int CNTW = $clog2(CMV + 1);
   localparam logic [XW-1:0] QLIM = XW'(1) << (DW - 1);

   typedef enum logic [3:0] {
      RD_IDLE = 4'b0001,
      RD_SQRT = 4'b0010,
      RD_DIV  = 4'b0100,
      RD_FIN  = 4'b1000
   } rd_state_type;

   rd_state_type         state_ff, state_in;
   logic [CNTW-1:0]      cnt_ff, cnt_in;
   logic [NW-1:0]        n_ff, n_in;
   logic [RMW-1:0]       srem_ff, srem_in;
   logic [RW-1:0]        root_ff, root_in;
   logic [DRW-1:0]       drem_ff, drem_in;
   logic [QW-1:0]        q_ff, q_in;
   logic                 neg_ff, neg_in;
   logic                 first_ff, first_in;
   logic                 done_ff, done_in;
   logic signed [DW-1:0] quot_ff, quot_in;

   logic [RMW-1:0]       rem_sh, trial;
   logic [DRW-1:0]       cand;
   logic [DW-1:0]        mag;
   logic                 rnd;
   logic [XW-1:0]        qr, qs;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      n_in     = n_ff;
      srem_in  = srem_ff;
      root_in  = root_ff;
      drem_in  = drem_ff;
      q_in     = q_ff;
      neg_in   = neg_ff;
      first_in = first_ff;
      done_in  = 1'b0;
      quot_in  = quot_ff;

      rem_sh = {srem_ff[RMW-3:0], n_ff[NW-1 -: 2]};
      trial  = (RMW'(root_ff) << 2) | RMW'(1);
      cand   = first_ff ? drem_ff : (drem_ff << 1);
      mag    = dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
      rnd    = ({drem_ff, 1'b0} >= (DRW + 1)'(root_ff));
      qr     = XW'(q_ff) + XW'(rnd);
      qs     = (qr > QLIM) ? QLIM : qr;

      case (state_ff)
         RD_IDLE: begin
            if (cmd.sqrt_go) begin
               n_in     = NW'(radicand);
               srem_in  = '0;
               root_in  = '0;
               cnt_in   = CNTW'(DW + 1);
               state_in = RD_SQRT;
            end else if (cmd.div_go) begin
               drem_in  = DRW'(mag);
               q_in     = '0;
               neg_in   = dividend[DW-1];
               first_in = 1'b1;
               cnt_in   = CNTW'(FRAC_BITS + 1);
               state_in = RD_DIV;
            end
         end
         RD_SQRT: begin
            // One root bit per cycle: two radicand bits shift into the remainder.
            if (rem_sh >= trial) begin
               srem_in = rem_sh - trial;
               root_in = {root_ff[RW-2:0], 1'b1};
            end else begin
               srem_in = rem_sh;
               root_in = {root_ff[RW-2:0], 1'b0};
            end
            n_in   = n_ff << 2;
            cnt_in = cnt_ff - CNTW'(1);
            if (cnt_ff == CNTW'(1)) begin
               done_in  = 1'b1;
               state_in = RD_IDLE;
            end
         end
         RD_DIV: begin
            // The magnitude never exceeds the root, so the quotient has FRAC_BITS+1 bits.
            if (cand >= DRW'(root_ff)) begin
               drem_in = cand - DRW'(root_ff);
               q_in    = {q_ff[QW-2:0], 1'b1};
            end else begin
               drem_in = cand;
               q_in    = {q_ff[QW-2:0], 1'b0};
            end
            first_in = 1'b0;
            cnt_in   = cnt_ff - CNTW'(1);
            if (cnt_ff == CNTW'(1)) begin
               state_in = RD_FIN;
            end
         end
         RD_FIN: begin
            if (neg_ff) begin
               quot_in = DW'(-qs);
            end else if (qs == QLIM) begin
               quot_in = {1'b0, {(DW-1){1'b1}}};
            end else begin
               quot_in = DW'(qs);
            end
            done_in  = 1'b1;
            state_in = RD_IDLE;
         end
         default: state_in = RD_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= RD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      n_ff     <= n_in;
      srem_ff  <= srem_in;
      root_ff  <= root_in;
      drem_ff  <= drem_in;
      q_ff     <= q_in;
      neg_ff   <= neg_in;
      first_ff <= first_in;
      quot_ff  <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

### rtl/qacc_checker.sv
module qacc_checker import qacc_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [((4*DATA_WIDTH+7)/8)*8-1:0]   req_tdata,
   input logic [2:0]                          req_tuser,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [((4*DATA_WIDTH+9)/8)*8-1:0]   rsp_tdata,
   input logic                                rsp_tlast,
   input logic                                rsp_tuser
);

   // A result that is not taken stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // Every request leaves the idle state on acceptance, so the block is busy right after one.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken on consecutive cycles");

   a_err_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && rsp_tdata[1:0] == 2'd0)
      else $error("error flag on a matrix row");

   a_row3_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] == 2'd3 |-> rsp_tlast)
      else $error("last matrix row not marked last");

endmodule

bind quaternion_accumulator_unit qacc_checker #(.DATA_WIDTH(DATA_WIDTH)) u_qacc_checker (.*);

### verif/tb_quaternion_accumulator_unit.sv
module tb_quaternion_accumulator_unit;
   import qacc_pkg::*;

   localparam int DW = 16;
   localparam int FB = 14;
   localparam int REQ_W = ((4*DW+7)/8)*8;
   localparam int RSP_W = ((4*DW+9)/8)*8;
   localparam longint QMAX = 32767;
   localparam longint QMIN = -32768;
   // Operation codes with no defined meaning.
   localparam logic [2:0] OP_SPARE6 = 3'd6;
   localparam logic [2:0] OP_SPARE7 = 3'd7;

   typedef struct {
      logic [1:0]  row;
      logic [15:0] c0, c1, c2, c3;
      logic        last;
      logic        err;
   } quat_result_type;

   class quat_scoreboard;
      longint ax, ay, az, aw;
      quat_result_type pending[$];
      int errors;
      int shown;

      function new();
         ax = 0; ay = 0; az = 0; aw = 16384;
         errors = 0; shown = 0;
      endfunction

      function longint clip(longint v);
         if (v > QMAX) return QMAX;
         if (v < QMIN) return QMIN;
         return v;
      endfunction

      // Exact product rounded half up to the fraction width.
      function longint rmul(longint a, longint b);
         longint p;
         p = a * b + (longint'(1) << (FB - 1));
         return p >>> FB;
      endfunction

      function longint unit_div(longint v, longint r);
         longint m, q;
         m = (v < 0 ? -v : v) << FB;
         q = m / r;
         if ((m % r) * 2 >= r) q++;
         return clip(v < 0 ? -q : q);
      endfunction

      function longint root(longint n);
         longint res, b;
         res = 0; b = longint'(1) << 62;
         while (b > n) b >>= 2;
         while (b != 0) begin
            if (n >= res + b) begin
               n -= res + b;
               res = (res >> 1) + b;
            end else begin
               res >>= 1;
            end
            b >>= 2;
         end
         return res;
      endfunction

      function void push(logic [1:0] r, longint a, longint b, longint c, longint d,
                         logic l, logic e);
         quat_result_type q;
         q.row = r;
         q.c0 = 16'(clip(a)); q.c1 = 16'(clip(b)); q.c2 = 16'(clip(c)); q.c3 = 16'(clip(d));
         q.last = l; q.err = e;
         pending.push_back(q);
      endfunction

      function void note_request(logic [2:0] op, logic signed [15:0] ix,
                                 logic signed [15:0] iy, logic signed [15:0] iz,
                                 logic signed [15:0] iw);
         longint X, Y, Z, W, x, y, z, w, ww, xx, yy, zz, xy, xz, yz, wx, wy, wz, s, r;
         logic e;
         X = ix; Y = iy; Z = iz; W = iw;
         x = ax; y = ay; z = az; w = aw;
         e = 1'b0;
         if (op == OP_MAT) begin
            ww = rmul(w, w); xx = rmul(x, x); yy = rmul(y, y); zz = rmul(z, z);
            xy = 2*rmul(x, y); xz = 2*rmul(x, z); yz = 2*rmul(y, z);
            wx = 2*rmul(w, x); wy = 2*rmul(w, y); wz = 2*rmul(w, z);
            push(2'd0, ww+xx-yy-zz, xy-wz, xz+wy, 0, 1'b0, 1'b0);
            push(2'd1, xy+wz, ww-xx+yy-zz, yz-wx, 0, 1'b0, 1'b0);
            push(2'd2, xz-wy, yz+wx, ww-xx-yy+zz, 0, 1'b0, 1'b0);
            push(2'd3, 0, 0, 0, ww+xx+yy+zz, 1'b1, 1'b0);
            return;
         end
         case (op)
            OP_LOAD: begin
               ax = X; ay = Y; az = Z; aw = W;
            end
            OP_MUL: begin
               ax = clip(rmul(w,X) + rmul(x,W) + rmul(y,Z) - rmul(z,Y));
               ay = clip(rmul(w,Y) + rmul(y,W) + rmul(z,X) - rmul(x,Z));
               az = clip(rmul(w,Z) + rmul(z,W) + rmul(x,Y) - rmul(y,X));
               aw = clip(rmul(w,W) - rmul(x,X) - rmul(y,Y) - rmul(z,Z));
            end
            OP_ADD: begin
               ax = clip(x+X); ay = clip(y+Y); az = clip(z+Z); aw = clip(w+W);
            end
            OP_CONJ: begin
               ax = clip(-x); ay = clip(-y); az = clip(-z);
            end
            OP_NORM: begin
               // Four 16-bit squares cannot overflow 64 bits.
               s = x*x + y*y + z*z + w*w;
               if (s == 0) begin
                  e = 1'b1;
               end else begin
                  r = root(s);
                  ax = unit_div(x, r); ay = unit_div(y, r);
                  az = unit_div(z, r); aw = unit_div(w, r);
               end
            end
            default: ;
         endcase
         push(2'd0, ax, ay, az, aw, 1'b1, e);
      endfunction

      function void check_result(logic [RSP_W-1:0] d, logic l, logic e);
         quat_result_type q;
         if (pending.size() == 0) begin
            errors++;
            if (shown < 10) begin
               shown++;
               $display("unexpected result data=%h last=%b err=%b", d, l, e);
            end
            return;
         end
         q = pending.pop_front();
         if (d[1:0] !== q.row || d[17:2] !== q.c0 || d[33:18] !== q.c1 ||
             d[49:34] !== q.c2 || d[65:50] !== q.c3 || l !== q.last || e !== q.err) begin
            errors++;
            if (shown < 10) begin
               shown++;
               $display("mismatch: expected row=%0d %h %h %h %h last=%b err=%b",
                        q.row, q.c0, q.c1, q.c2, q.c3, q.last, q.err);
               $display("          actual   row=%0d %h %h %h %h last=%b err=%b",
                        d[1:0], d[17:2], d[33:18], d[49:34], d[65:50], l, e);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic [2:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic rsp_tlast;
   logic rsp_tuser;

   int send_idle_pct = 16;
   int recv_idle_pct = 61;
   int hold_cycles = 0;
   quat_scoreboard sb;

   quaternion_accumulator_unit dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("Test completed with failures");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tlast, rsp_tuser);
      if (!reset && req_tvalid && req_tready)
         sb.note_request(req_tuser, req_tdata[15:0], req_tdata[31:16], req_tdata[47:32],
                         req_tdata[63:48]);
   end

   // Receiver: random stalls, or a long hold-off when requested.
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // The request stays offered after acceptance until the next send or drain replaces it.
   task automatic send(logic [2:0] op, logic [15:0] x, logic [15:0] y, logic [15:0] z,
                       logic [15:0] w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {w, z, y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic logic [15:0] rnd_unit();
      return 16'($urandom_range(32767) - 16384);
   endfunction

   function automatic logic [15:0] rnd_val();
      case ($urandom_range(5))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return rnd_unit();
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic random_phase(int n);
      logic [2:0] op;
      for (int i = 0; i < n; i++) begin
         op = 3'($urandom_range(7));
         // Keep the accumulator near unit size most of the time.
         if (op == OP_LOAD && $urandom_range(1))
            send(op, rnd_unit(), rnd_unit(), rnd_unit(), rnd_unit());
         else
            send(op, rnd_val(), rnd_val(), rnd_val(), rnd_val());
      end
   endtask

   initial begin
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed part: matrix of the reset identity, extremes, zero norm.
      send(OP_MAT, 0, 0, 0, 0);
      send(OP_NORM, 0, 0, 0, 0);
      send(OP_LOAD, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
      send(OP_MAT, 0, 0, 0, 0);
      send(OP_CONJ, 0, 0, 0, 0);
      send(OP_ADD, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
      send(OP_MUL, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
      send(OP_NORM, 0, 0, 0, 0);
      send(OP_MAT, 0, 0, 0, 0);
      send(OP_LOAD, 0, 0, 0, 0);
      send(OP_NORM, 0, 0, 0, 0);
      send(OP_CONJ, 0, 0, 0, 0);
      send(OP_LOAD, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send(OP_CONJ, 0, 0, 0, 0);
      send(OP_NORM, 0, 0, 0, 0);
      send(OP_SPARE6, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
      send(OP_SPARE7, 0, 0, 0, 0);
      send(OP_LOAD, 1, 0, 0, 0);
      send(OP_NORM, 0, 0, 0, 0);
      send(OP_MUL, 16'h4000, 16'h4000, 16'h4000, 16'h4000);
      send(OP_MAT, 0, 0, 0, 0);
      // Sender waits for every result before going on.
      drain();
      random_phase(60);
      // Long receiver hold-off while requests keep coming.
      hold_cycles = 400;
      random_phase(10);
      drain();
      send_idle_pct = 61; recv_idle_pct = 16;
      random_phase(60);
      send_idle_pct = 0; recv_idle_pct = 0;
      random_phase(70);
      drain();
      if (sb.errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
